[hw/rtl/rrm_pkg.sv]
// shared types and constants of the ring robot motion controller
// no dependencies
package rrm_pkg;

  typedef enum logic [7:0] {
    MODE_WAIT   = 8'b0000_0001,
    MODE_SEARCH = 8'b0000_0010,
    MODE_GO     = 8'b0000_0100,
    MODE_HALF   = 8'b0000_1000,
    MODE_QLEFT  = 8'b0001_0000,
    MODE_QRIGHT = 8'b0010_0000,
    MODE_ESC    = 8'b0100_0000,
    MODE_ESC2   = 8'b1000_0000
  } mode_e;

  localparam logic [2:0] CODE_WAIT   = 3'd0;
  localparam logic [2:0] CODE_SEARCH = 3'd1;
  localparam logic [2:0] CODE_GO     = 3'd2;
  localparam logic [2:0] CODE_HALF   = 3'd3;
  localparam logic [2:0] CODE_QLEFT  = 3'd4;
  localparam logic [2:0] CODE_QRIGHT = 3'd5;
  localparam logic [2:0] CODE_ESC    = 3'd6;
  localparam logic [2:0] CODE_ESC2   = 3'd7;

  localparam logic [2:0] DIR_FL   = 3'd0;
  localparam logic [2:0] DIR_FR   = 3'd1;
  localparam logic [2:0] DIR_BL   = 3'd2;
  localparam logic [2:0] DIR_BR   = 3'd3;
  localparam logic [2:0] DIR_FWD  = 3'd4;
  localparam logic [2:0] DIR_BACK = 3'd5;

  localparam logic [2:0] REG_GO_TICKS      = 3'd0;
  localparam logic [2:0] REG_ESC_TICKS     = 3'd1;
  localparam logic [2:0] REG_ESC2_TICKS    = 3'd2;
  localparam logic [2:0] REG_QUARTER_TICKS = 3'd3;
  localparam logic [2:0] REG_HALF_TICKS    = 3'd4;

  localparam logic [15:0] GO_TICKS_RST      = 16'd1000;
  localparam logic [15:0] ESC_TICKS_RST     = 16'd8000;
  localparam logic [15:0] ESC2_TICKS_RST    = 16'd2000;
  localparam logic [15:0] QUARTER_TICKS_RST = 16'd8000;
  localparam logic [15:0] HALF_TICKS_RST    = 16'd16000;

  localparam logic signed [8:0] SPD_FWD      = 9'sd255;
  localparam logic signed [8:0] SPD_REV      = -9'sd255;
  localparam logic signed [8:0] SPD_REV_SOFT = -9'sd205;
  localparam logic signed [8:0] SPD_FWD_SOFT = 9'sd105;
  localparam logic signed [8:0] SPD_STOP     = 9'sd0;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    c = CODE_WAIT;
    case (m)
      MODE_WAIT:   c = CODE_WAIT;
      MODE_SEARCH: c = CODE_SEARCH;
      MODE_GO:     c = CODE_GO;
      MODE_HALF:   c = CODE_HALF;
      MODE_QLEFT:  c = CODE_QLEFT;
      MODE_QRIGHT: c = CODE_QRIGHT;
      MODE_ESC:    c = CODE_ESC;
      MODE_ESC2:   c = CODE_ESC2;
      default:     c = CODE_WAIT;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/ring_robot_motion_fsm_unit.sv]
// ring robot motion controller: one control tick in, one motor command out
// depends on rrm_pkg
//
// usage: each transfer on the s_axis side is one control tick carrying the
// sonar, side range, edge line, button and start-delay readings. each tick
// produces exactly one transfer on the m_axis side with the left and right
// motor speeds, the drive-update flag, the start-timer request and the new
// mode code. limits are written through cfg_we_i / cfg_idx_i / cfg_data_i
// while the unit is idle; an index above four is ignored.
// the tick goes into an input register, the combinational mode update reads
// it and the result lands in the output register: m_axis_tvalid_o rises once
// the output register is loaded. one tick per cycle is sustained while the
// receiver takes each output; the mode and counter update is combinational.
// reset puts the unit in wait mode with the counter, escape direction and
// start latch cleared and the limits at their defaults. when the receiver
// stalls the output register holds and the input register fills, then
// s_axis_tready_o drops; nothing is lost or repeated.
module ring_robot_motion_fsm_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // sonar_distance[15:0], range_left[31:16], range_right[47:32],
  // edge_front_left[48], edge_front_right[49], edge_back_left[50],
  // edge_back_right[51], button_pressed[52], start_delay_active[53]
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // left_speed[8:0], right_speed[17:9], drive_update[18],
  // start_timer_request[19], mode_code[22:20]
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import rrm_pkg::*;

  logic [15:0] go_ticks_q, esc_ticks_q, esc2_ticks_q, quarter_ticks_q, half_ticks_q;

  logic        in_valid_q;
  logic [53:0] in_data_q;

  mode_e       mode_q, mode_d;
  logic [15:0] cnt_q, cnt_d;
  logic [2:0]  dir_q, dir_d;
  logic        latch_q, latch_d;

  logic              out_valid_q;
  logic signed [8:0] left_q, right_q, left_d, right_d;
  logic              upd_q, upd_d;
  logic              treq_q, treq_d;
  logic [2:0]        code_q;

  logic advance;
  logic sonar, rl, rr, fl, fr, bl, br, button, delay, any_edge;
  logic [15:0] cnt_inc;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_ticks_q      <= GO_TICKS_RST;
      esc_ticks_q     <= ESC_TICKS_RST;
      esc2_ticks_q    <= ESC2_TICKS_RST;
      quarter_ticks_q <= QUARTER_TICKS_RST;
      half_ticks_q    <= HALF_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GO_TICKS:      go_ticks_q      <= cfg_data_i;
        REG_ESC_TICKS:     esc_ticks_q     <= cfg_data_i;
        REG_ESC2_TICKS:    esc2_ticks_q    <= cfg_data_i;
        REG_QUARTER_TICKS: quarter_ticks_q <= cfg_data_i;
        REG_HALF_TICKS:    half_ticks_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i[53:0];
    end
  end

  assign sonar    = |in_data_q[15:0];
  assign rl       = |in_data_q[31:16];
  assign rr       = |in_data_q[47:32];
  assign fl       = in_data_q[48];
  assign fr       = in_data_q[49];
  assign bl       = in_data_q[50];
  assign br       = in_data_q[51];
  assign button   = in_data_q[52];
  assign delay    = in_data_q[53];
  assign any_edge = fl | fr | bl | br;
  assign cnt_inc  = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 16'd1;

  // mode update
  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    dir_d   = dir_q;
    latch_d = latch_q;
    left_d  = SPD_STOP;
    right_d = SPD_STOP;
    upd_d   = 1'b0;
    treq_d  = 1'b0;
    case (mode_q)
      MODE_WAIT: begin
        if (button && !latch_q) begin
          treq_d  = 1'b1;
          latch_d = 1'b1;
        end
        if (!delay) begin
          mode_d = (!sonar && !rl && !rr) ? MODE_HALF : MODE_SEARCH;
        end
      end
      MODE_SEARCH: begin
        if (any_edge) begin
          cnt_d  = 16'd0;
          mode_d = MODE_ESC;
        end else if (sonar) begin
          cnt_d  = 16'd0;
          mode_d = MODE_GO;
        end else if (rl) begin
          cnt_d  = 16'd0;
          mode_d = MODE_QLEFT;
        end else if (rr) begin
          cnt_d  = 16'd0;
          mode_d = MODE_QRIGHT;
        end else begin
          left_d  = SPD_FWD;
          right_d = SPD_FWD;
          upd_d   = 1'b1;
        end
      end
      MODE_GO: begin
        left_d  = SPD_FWD;
        right_d = SPD_FWD;
        upd_d   = 1'b1;
        cnt_d   = cnt_inc;
        if (any_edge) begin
          cnt_d  = 16'd0;
          mode_d = MODE_ESC;
        end else if (!sonar && cnt_inc > go_ticks_q) begin
          cnt_d  = 16'd0;
          mode_d = MODE_SEARCH;
        end
      end
      MODE_HALF, MODE_QLEFT, MODE_QRIGHT: begin
        upd_d   = 1'b1;
        left_d  = (mode_q == MODE_QLEFT) ? SPD_REV : SPD_FWD;
        right_d = (mode_q == MODE_QLEFT) ? SPD_FWD : SPD_REV;
        cnt_d   = cnt_inc;
        if (any_edge) begin
          cnt_d  = 16'd0;
          mode_d = MODE_ESC;
        end else if (cnt_inc > ((mode_q == MODE_HALF) ? half_ticks_q : quarter_ticks_q)) begin
          left_d  = SPD_FWD;
          right_d = SPD_FWD;
          cnt_d   = 16'd0;
          mode_d  = MODE_GO;
        end
      end
      MODE_ESC: begin
        cnt_d = cnt_inc;
        if (fl || fr) begin
          cnt_d   = 16'd0;
          left_d  = SPD_REV;
          right_d = SPD_REV;
          upd_d   = 1'b1;
          dir_d   = (fl && fr) ? DIR_BACK : (fl ? DIR_BL : DIR_BR);
        end
        if (bl || br) begin
          cnt_d   = 16'd0;
          left_d  = SPD_FWD;
          right_d = SPD_FWD;
          upd_d   = 1'b1;
          dir_d   = (bl && br) ? DIR_FWD : (bl ? DIR_FR : DIR_FL);
        end
        if (cnt_d > esc_ticks_q) begin
          cnt_d  = 16'd0;
          mode_d = MODE_ESC2;
        end
      end
      MODE_ESC2: begin
        cnt_d = cnt_inc;
        if (any_edge) begin
          cnt_d  = 16'd0;
          mode_d = MODE_ESC;
        end else begin
          upd_d = 1'b1;
          case (dir_q)
            DIR_FWD: begin
              left_d  = SPD_FWD;
              right_d = SPD_FWD;
            end
            DIR_BACK: begin
              left_d  = SPD_REV;
              right_d = SPD_REV;
            end
            DIR_FL: begin
              left_d  = SPD_REV_SOFT;
              right_d = SPD_FWD;
            end
            DIR_FR: begin
              left_d  = SPD_FWD;
              right_d = SPD_REV_SOFT;
            end
            DIR_BL: begin
              left_d  = SPD_FWD_SOFT;
              right_d = SPD_REV;
            end
            DIR_BR: begin
              left_d  = SPD_REV;
              right_d = SPD_FWD_SOFT;
            end
            default: upd_d = 1'b0;
          endcase
          if (cnt_inc >= esc2_ticks_q) begin
            cnt_d   = 16'd0;
            left_d  = SPD_STOP;
            right_d = SPD_STOP;
            upd_d   = 1'b1;
            mode_d  = MODE_SEARCH;
          end
        end
      end
      default: begin
        mode_d = MODE_WAIT;
      end
    endcase
  end

  // state, updated once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_WAIT;
      cnt_q   <= 16'd0;
      dir_q   <= DIR_FL;
      latch_q <= 1'b0;
    end else if (advance) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      dir_q   <= dir_d;
      latch_q <= latch_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      left_q  <= left_d;
      right_q <= right_d;
      upd_q   <= upd_d;
      treq_q  <= treq_d;
      code_q  <= mode_code(mode_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, code_q, treq_q, upd_q, right_q, left_q};

endmodule
